// ===== rtl/cmh_pkg.sv =====
// Shared constants and command codes for the chained hash map.
`timescale 1ns / 1ps
`default_nettype none
package cmh_pkg;

    localparam int CMD_W      = 2;
    localparam int KEY_PORT_W = 64;
    localparam int BYTE_W     = 8;
    localparam int TMPL_W     = 2;
    localparam int FUN_W      = 4;
    localparam int LIKES_W    = 14;
    localparam int VAL_W      = TMPL_W + FUN_W + LIKES_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/chained_hash_map.sv =====
// Top level: separate-chaining hash map with a bounded node pool kept in RAM.
//
//  channel   | handshake        | ports
//  ----------+------------------+-----------------------------------------------------
//  request   | start & !busy    | cmd, key, template_id, fun_level, like_count
//  result    | done (1 cycle)   | hit, found_template, found_fun, found_likes,
//            |                  | entry_count, status
//
// busy stays high while the serial byte hash runs, the bucket head is read and the chain
// is walked node by node through the registered-read key/link RAMs; a match ends the walk.
// A new insert then takes a node from the free list and an erase relinks and frees the
// node; a no-op ends once the hash is done.
// After reset a clearing pass over max(CAPACITY, NUM_BUCKETS) entries empties the
// buckets and threads the free list; busy stays high through it.
// The result receiver cannot stall; each result is one cycle on the done strobe.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_map #(
    parameter int CAPACITY    = 1024,
    parameter int NUM_BUCKETS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cmh_pkg::CMD_W-1:0]     cmd,
    input  wire logic [cmh_pkg::KEY_PORT_W-1:0] key,
    input  wire logic [cmh_pkg::TMPL_W-1:0]    template_id,
    input  wire logic [cmh_pkg::FUN_W-1:0]     fun_level,
    input  wire logic [cmh_pkg::LIKES_W-1:0]   like_count,
    output logic                               done,
    output logic                               hit,
    output logic [cmh_pkg::TMPL_W-1:0]         found_template,
    output logic [cmh_pkg::FUN_W-1:0]          found_fun,
    output logic [cmh_pkg::LIKES_W-1:0]        found_likes,
    output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
    output logic                               status
);
    import cmh_pkg::*;

    localparam int KEY_W     = BYTE_W * KEY_BYTES;
    localparam int LW        = $clog2(CAPACITY + 1);
    localparam int AW        = $clog2(CAPACITY);
    localparam int BKT_W     = $clog2(NUM_BUCKETS);
    localparam int CLR_DEPTH = (CAPACITY > NUM_BUCKETS) ? CAPACITY : NUM_BUCKETS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD_RD,
        S_HEAD,
        S_CHECK,
        S_NODE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_ERASE_LINK,
        S_ERASE_FREE
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BKT_W-1:0] bucket_reg;
    logic [LW-1:0]    head_reg;
    logic [LW-1:0]    cur_reg;
    logic [LW-1:0]    prev_reg;
    logic [LW-1:0]    next_reg;
    logic [LW-1:0]    free_reg;
    logic [LW-1:0]    count_reg;
    logic [CLR_W-1:0] clr_reg;
    logic             done_reg;
    logic             hit_reg;
    logic             status_reg;
    logic [VAL_W-1:0] found_reg;

    logic             hash_start;
    logic             hash_done;
    logic [BKT_W-1:0] hash_bucket;

    logic             heads_we;
    logic [BKT_W-1:0] heads_waddr;
    logic [LW-1:0]    heads_wdata;
    logic [LW-1:0]    heads_rdata;
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [LW-1:0]    link_wdata;
    logic [AW-1:0]    link_raddr;
    logic [LW-1:0]    link_rdata;
    logic             node_we;
    logic             val_we;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;

    logic clr_heads;
    logic clr_links;
    logic pool_full;

    assign hash_start = (state_reg == S_IDLE) && start;
    assign clr_heads  = {1'b0, clr_reg} < (CLR_W+1)'(NUM_BUCKETS);
    assign clr_links  = {1'b0, clr_reg} < (CLR_W+1)'(CAPACITY);
    assign pool_full  = (count_reg == NIL) || (free_reg == NIL);

    cmh_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key[KEY_W-1:0]),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // memory write ports, driven from the current state
    always_comb
    begin
        heads_we    = 1'b0;
        heads_waddr = bucket_reg;
        heads_wdata = next_reg;
        link_we     = 1'b0;
        link_waddr  = cur_reg[AW-1:0];
        link_wdata  = free_reg;
        node_we     = 1'b0;
        val_we      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                heads_we    = clr_heads;
                heads_waddr = clr_reg[BKT_W-1:0];
                heads_wdata = NIL;
                link_we     = clr_links;
                link_waddr  = clr_reg[AW-1:0];
                link_wdata  = LW'({1'b0, clr_reg} + (CLR_W+1)'(1));
            end
            S_NODE:
            begin
                val_we = (key_rdata == key_reg) && (cmd_reg == CMD_INSERT);
            end
            S_ALLOC_WR:
            begin
                node_we     = 1'b1;
                val_we      = 1'b1;
                link_we     = 1'b1;
                link_waddr  = free_reg[AW-1:0];
                link_wdata  = head_reg;
                heads_we    = 1'b1;
                heads_wdata = free_reg;
            end
            S_ERASE_LINK:
            begin
                // unhook the node from its predecessor or from the bucket head
                if (prev_reg == NIL)
                begin
                    heads_we = 1'b1;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[AW-1:0];
                    link_wdata = next_reg;
                end
            end
            S_ERASE_FREE:
            begin
                link_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign link_raddr = (state_reg == S_ALLOC_RD || state_reg == S_ALLOC_WR) ?
                        free_reg[AW-1:0] : cur_reg[AW-1:0];

    cmh_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (heads_we),
        .waddr (heads_waddr),
        .wdata (heads_wdata),
        .raddr (bucket_reg),
        .rdata (heads_rdata)
    );

    cmh_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    cmh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
        .clk   (clk),
        .we    (node_we),
        .waddr (free_reg[AW-1:0]),
        .wdata (key_reg),
        .raddr (cur_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    cmh_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_vals (
        .clk   (clk),
        .we    (val_we),
        .waddr ((state_reg == S_ALLOC_WR) ? free_reg[AW-1:0] : cur_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (cur_reg[AW-1:0]),
        .rdata (val_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= 1'b0;
            found_reg  <= '0;
            cmd_reg    <= CMD_NOP;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd_t'(cmd);
                        key_reg   <= key[KEY_W-1:0];
                        val_reg   <= {like_count, fun_level, template_id};
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        bucket_reg <= hash_bucket;
                        if (cmd_reg == CMD_NOP)
                        begin
                            done_reg   <= 1'b1;
                            hit_reg    <= 1'b0;
                            status_reg <= 1'b0;
                            found_reg  <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_HEAD_RD;
                        end
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    head_reg  <= heads_rdata;
                    cur_reg   <= heads_rdata;
                    prev_reg  <= NIL;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (cur_reg == NIL)
                    begin
                        if (cmd_reg == CMD_INSERT && !pool_full)
                        begin
                            state_reg <= S_ALLOC_RD;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            hit_reg    <= 1'b0;
                            status_reg <= (cmd_reg == CMD_INSERT);
                            found_reg  <= '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_NODE;
                    end
                end
                S_NODE:
                begin
                    if (key_rdata == key_reg)
                    begin
                        next_reg <= link_rdata;
                        if (cmd_reg == CMD_ERASE)
                        begin
                            state_reg <= S_ERASE_LINK;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            hit_reg    <= 1'b1;
                            status_reg <= 1'b0;
                            found_reg  <= (cmd_reg == CMD_FIND) ? val_rdata : '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= link_rdata;
                        state_reg <= S_CHECK;
                    end
                end
                S_ALLOC_RD:
                begin
                    state_reg <= S_ALLOC_WR;
                end
                S_ALLOC_WR:
                begin
                    free_reg   <= link_rdata;
                    count_reg  <= count_reg + LW'(1);
                    done_reg   <= 1'b1;
                    hit_reg    <= 1'b0;
                    status_reg <= 1'b0;
                    found_reg  <= '0;
                    state_reg  <= S_IDLE;
                end
                S_ERASE_LINK:
                begin
                    state_reg <= S_ERASE_FREE;
                end
                S_ERASE_FREE:
                begin
                    // push the node onto the free list
                    free_reg   <= cur_reg;
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - LW'(1);
                    end
                    done_reg   <= 1'b1;
                    hit_reg    <= 1'b1;
                    status_reg <= 1'b0;
                    found_reg  <= '0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign status         = status_reg;
    assign found_template = found_reg[TMPL_W-1:0];
    assign found_fun      = found_reg[TMPL_W+FUN_W-1:TMPL_W];
    assign found_likes    = found_reg[VAL_W-1:TMPL_W+FUN_W];
    assign entry_count    = count_reg;

endmodule
`default_nettype wire

// ===== rtl/cmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/cmh_hash.sv =====
// Byte-serial bucket hash: sum of byte i times ten to the i, modulo 2**$clog2(NUM_BUCKETS).
`timescale 1ns / 1ps
`default_nettype none
module cmh_hash #(
    parameter int NUM_BUCKETS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [8*KEY_BYTES-1:0]         key,
    output logic                                done,
    output logic [$clog2(NUM_BUCKETS)-1:0]      bucket
);
    import cmh_pkg::*;

    localparam int BKT_W = $clog2(NUM_BUCKETS);
    localparam int KEY_W = BYTE_W * KEY_BYTES;
    localparam int BC_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [KEY_W-1:0] key_reg;
    logic [BKT_W-1:0] sum_reg;
    logic [BKT_W-1:0] scale_reg;
    logic [BC_W-1:0]  left_reg;
    logic             run_reg;
    logic             done_reg;

    logic [BKT_W+BYTE_W-1:0] prod;
    logic [BKT_W-1:0]        sum_next;
    logic [BKT_W-1:0]        scale_next;

    always_comb
    begin
        prod       = (BKT_W+BYTE_W)'(key_reg[BYTE_W-1:0]) * (BKT_W+BYTE_W)'(scale_reg);
        sum_next   = sum_reg + prod[BKT_W-1:0];
        scale_next = BKT_W'((BKT_W+4)'(scale_reg) * (BKT_W+4)'(10));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                key_reg   <= key;
                sum_reg   <= '0;
                scale_reg <= BKT_W'(1);
                left_reg  <= BC_W'(KEY_BYTES - 1);
            end
            else if (run_reg)
            begin
                // advance one key byte per cycle
                sum_reg   <= sum_next;
                scale_reg <= scale_next;
                key_reg   <= key_reg >> BYTE_W;
                left_reg  <= left_reg - BC_W'(1);
                if (left_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign bucket = sum_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_chained_hash_map.sv =====
// Self-checking testbench for the chained hash map: random and directed requests.
`timescale 1ns / 1ps
module tb_chained_hash_map;
    import cmh_pkg::*;

    localparam int POOL_SIZE    = 1024;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 380;

    typedef struct {
        cmd_t              op;
        logic [63:0]       k;
        logic [TMPL_W-1:0] tmpl;
        logic [FUN_W-1:0]  fun;
        logic [LIKES_W-1:0] likes;
    } request_t;

    typedef struct {
        logic               hit;
        logic [TMPL_W-1:0]  tmpl;
        logic [FUN_W-1:0]   fun;
        logic [LIKES_W-1:0] likes;
        logic [10:0]        count;
        logic               status;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [CMD_W-1:0] cmd = '0;
    logic [63:0] key = '0;
    logic [TMPL_W-1:0] template_id = '0;
    logic [FUN_W-1:0] fun_level = '0;
    logic [LIKES_W-1:0] like_count = '0;
    wire busy, done, hit, status;
    wire [TMPL_W-1:0] found_template;
    wire [FUN_W-1:0] found_fun;
    wire [LIKES_W-1:0] found_likes;
    wire [10:0] entry_count;

    chained_hash_map dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .key(key),
        .template_id(template_id), .fun_level(fun_level), .like_count(like_count),
        .done(done), .hit(hit), .found_template(found_template), .found_fun(found_fun),
        .found_likes(found_likes), .entry_count(entry_count), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    logic [VAL_W-1:0] map_values[logic [63:0]];
    int       map_size = 0;
    logic     req_taken = 1'b0;
    int       sent_count = 0;
    int       stall_cycles = 0;
    bit       failed = 1'b0;
    logic [63:0] key_pool[64];

    // Map semantics of the table: lookup, replace, bounded insert, erase.
    function automatic reply_t apply_request(request_t r);
        reply_t e;
        logic   present;
        e = '{default: '0};
        present = (r.op != CMD_NOP) && map_values.exists(r.k);
        e.hit = present;
        case (r.op)
            CMD_INSERT:
            begin
                if (present || map_size < POOL_SIZE)
                begin
                    if (!present)
                        map_size++;
                    map_values[r.k] = {r.likes, r.fun, r.tmpl};
                end
                else
                    e.status = 1'b1;
            end
            CMD_FIND:
            begin
                if (present)
                    {e.likes, e.fun, e.tmpl} = map_values[r.k];
            end
            CMD_ERASE:
            begin
                if (present)
                begin
                    map_values.delete(r.k);
                    map_size--;
                end
            end
            default: ;
        endcase
        e.count = map_size[10:0];
        return e;
    endfunction

    function automatic request_t make_req(cmd_t op, logic [63:0] k);
        request_t r;
        r.op = op;
        r.k = k;
        r.tmpl = TMPL_W'($urandom);
        r.fun = FUN_W'($urandom);
        r.likes = LIKES_W'($urandom);
        return r;
    endfunction

    // Monitor: check results, then record accepted requests.
    always @(posedge clk)
    begin
        reply_t e;
        request_t r;
        if (done)
        begin
            stall_cycles = 0;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                failed = 1'b1;
            end
            else
            begin
                e = expected_replies.pop_front();
                if (hit !== e.hit || found_template !== e.tmpl || found_fun !== e.fun ||
                    found_likes !== e.likes || entry_count !== e.count ||
                    status !== e.status)
                begin
                    $display("%0t: mismatch expected hit=%0d tmpl=%0d fun=%0d likes=%0d",
                             $time, e.hit, e.tmpl, e.fun, e.likes,
                             " cnt=%0d st=%0d", e.count, e.status);
                    $display("%0t:          actual  hit=%0d tmpl=%0d fun=%0d likes=%0d",
                             $time, hit, found_template, found_fun, found_likes,
                             " cnt=%0d st=%0d", entry_count, status);
                    failed = 1'b1;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            stall_cycles = 0;
            r.op = cmd_t'(cmd);
            r.k = key;
            r.tmpl = template_id;
            r.fun = fun_level;
            r.likes = like_count;
            expected_replies.push_back(apply_request(r));
            req_taken = 1'b1;
        end
        stall_cycles++;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Driver: advance on each transfer; idle at random outside the quiet stretch.
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && (!start || req_taken))
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 &&
                ((sent_count > 150 && sent_count < 260) || $urandom_range(99) >= 34))
            begin
                r = pending_reqs.pop_front();
                sent_count++;
                start <= 1'b1;
                cmd <= r.op;
                key <= r.k;
                template_id <= r.tmpl;
                fun_level <= r.fun;
                like_count <= r.likes;
            end
            else
                start <= 1'b0;
        end
    end

    initial
    begin
        request_t r;
        int pick;
        logic [63:0] k;
        // Keys 0x0A and 0x0100 share a bucket, as do 0x14 and 0x0200.
        pending_reqs.push_back(make_req(CMD_FIND, 64'h0));
        pending_reqs.push_back(make_req(CMD_ERASE, 64'h0));
        pending_reqs.push_back(make_req(CMD_NOP, 64'h0A));
        r = make_req(CMD_INSERT, 64'h0);
        r.tmpl = '0; r.fun = '0; r.likes = '0;
        pending_reqs.push_back(r);
        r = make_req(CMD_INSERT, '1);
        r.tmpl = '1; r.fun = '1; r.likes = '1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_FIND, '1));
        pending_reqs.push_back(make_req(CMD_FIND, 64'h0));
        pending_reqs.push_back(make_req(CMD_INSERT, 64'h0A));
        pending_reqs.push_back(make_req(CMD_INSERT, 64'h0100));
        pending_reqs.push_back(make_req(CMD_INSERT, 64'h14));
        pending_reqs.push_back(make_req(CMD_INSERT, 64'h0200));
        pending_reqs.push_back(make_req(CMD_INSERT, 64'h0A));
        pending_reqs.push_back(make_req(CMD_FIND, 64'h0A));
        pending_reqs.push_back(make_req(CMD_ERASE, 64'h0100));
        pending_reqs.push_back(make_req(CMD_FIND, 64'h0A));
        pending_reqs.push_back(make_req(CMD_ERASE, 64'h0A));
        pending_reqs.push_back(make_req(CMD_FIND, 64'h0100));
        pending_reqs.push_back(make_req(CMD_NOP, '1));
        pending_reqs.push_back(make_req(CMD_ERASE, '1));
        pending_reqs.push_back(make_req(CMD_FIND, '1));

        for (int i = 0; i < 64; i++)
        begin
            if (i < 32)
                key_pool[i] = {$urandom, $urandom};
            else
                key_pool[i] = {48'h0, 8'($urandom_range(2)), 8'(10 * $urandom_range(2))};
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            k = ($urandom_range(99) < 15) ? {$urandom, $urandom} : key_pool[$urandom_range(63)];
            if (pick < 40)
                r = make_req(CMD_INSERT, k);
            else if (pick < 70)
                r = make_req(CMD_FIND, k);
            else if (pick < 95)
                r = make_req(CMD_ERASE, k);
            else
                r = make_req(CMD_NOP, k);
            pending_reqs.push_back(r);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !req_taken && !start);
        wait (expected_replies.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!failed && expected_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
